[hdl/ssd_pkg.sv]
// Shared widths, types and helper functions for the segment distance pipeline.
package ssd_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PP_W    = 2 * DIFF_W;
  localparam int DOT_W   = PP_W + 1;
  localparam int ALT_W   = DOT_W + 1;
  localparam int WIDE_W  = 104;
  localparam int DIV_W   = 102;
  localparam int QBITS   = 32;
  localparam int FRAC_W  = QBITS + 1;
  localparam int TERM_W  = FRAC_W + DIFF_W + 1;
  localparam int MUL_W   = 60;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = 118;
  localparam int OUT_W   = 52;
  localparam int THR_W   = 16;
  localparam int MUL_LAT = 3;

  localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(1) << QBITS;
  localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (2 * QBITS - 1);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [ALT_W-1:0]  alt_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [MUL_W-1:0]  mulin_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [FRAC_W-1:0]        frac_t;
  typedef logic [SUM_W-1:0]         sum_t;

  typedef enum logic [1:0] {
    DIV_ZERO,
    DIV_ONE,
    DIV_RUN
  } div_mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] seg_a_start_x;
    logic [COORD_W-1:0] seg_a_start_y;
    logic [COORD_W-1:0] seg_a_start_z;
    logic [COORD_W-1:0] seg_a_end_x;
    logic [COORD_W-1:0] seg_a_end_y;
    logic [COORD_W-1:0] seg_a_end_z;
    logic [COORD_W-1:0] seg_b_start_x;
    logic [COORD_W-1:0] seg_b_start_y;
    logic [COORD_W-1:0] seg_b_start_z;
    logic [COORD_W-1:0] seg_b_end_x;
    logic [COORD_W-1:0] seg_b_end_y;
    logic [COORD_W-1:0] seg_b_end_z;
  } seg_pair_t;

  typedef struct packed {
    logic [OUT_W-1:0] distance_sq;
    logic             saturated;
  } dist_item_t;

  typedef struct {
    diff_t u [3];
    diff_t v [3];
    diff_t w [3];
  } vec_t;

  typedef struct {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t d;
    dot_t e;
  } dots_t;

  function automatic diff_t sub_c(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    sub_c = $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
  endfunction

  function automatic pp_t mul_d(input diff_t x, input diff_t y);
    mul_d = pp_t'(x) * pp_t'(y);
  endfunction

  // |x| below the threshold
  function automatic logic is_near(input wide_t x, input logic [THR_W-1:0] thr);
    wide_t t;
    t = WIDE_W'(thr);
    is_near = (x < t) && (x > -t);
  endfunction

  function automatic div_mode_t div_mode(input wide_t num, input wide_t den,
                                         input logic [THR_W-1:0] thr);
    wide_t zero;
    zero = '0;
    if (is_near(num, thr) || num <= zero || den <= zero) begin
      div_mode = DIV_ZERO;
    end else if (num >= den) begin
      div_mode = DIV_ONE;
    end else begin
      div_mode = DIV_RUN;
    end
  endfunction

endpackage

[hdl/ssd_mul.sv]
// Three-stage signed multiplier built from four half-width partial products.
module ssd_mul (
  input  logic           clk,
  input  logic           en,
  input  ssd_pkg::mulin_t a,
  input  ssd_pkg::mulin_t b,
  output ssd_pkg::prod_t  p
);
  import ssd_pkg::*;

  localparam int HALF = MUL_W / 2;

  logic [MUL_W-1:0]  mag_a, mag_b;
  logic [MUL_W-1:0]  pp_ll, pp_lh, pp_hl, pp_hh;
  logic              neg1, neg2;
  logic [MUL_W:0]    mid;
  logic [PROD_W-1:0] mag_p;

  assign mag_a = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
  assign mag_b = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
  assign mid   = {1'b0, pp_lh} + {1'b0, pp_hl};

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= mag_a[HALF-1:0] * mag_b[HALF-1:0];
      pp_lh <= mag_a[HALF-1:0] * mag_b[MUL_W-1:HALF];
      pp_hl <= mag_a[MUL_W-1:HALF] * mag_b[HALF-1:0];
      pp_hh <= mag_a[MUL_W-1:HALF] * mag_b[MUL_W-1:HALF];
      neg1  <= a[MUL_W-1] ^ b[MUL_W-1];
      mag_p <= {pp_hh, pp_ll} + (PROD_W'(mid) << HALF);
      neg2  <= neg1;
      p     <= neg2 ? -$signed(mag_p) : $signed(mag_p);
    end
  end

endmodule

[hdl/ssd_div.sv]
// Pipelined restoring divider: one quotient bit per stage, Q1.32 result.
module ssd_div (
  input  logic               clk,
  input  logic               en,
  input  ssd_pkg::div_mode_t mode,
  input  logic [ssd_pkg::DIV_W-1:0] num,
  input  logic [ssd_pkg::DIV_W-1:0] den,
  output ssd_pkg::frac_t     frac
);
  import ssd_pkg::*;

  logic [DIV_W-1:0] rem_r  [QBITS];
  logic [DIV_W-1:0] den_r  [QBITS];
  logic [QBITS-1:0] quo_r  [QBITS];
  div_mode_t        mode_r [QBITS];

  for (genvar i = 0; i < QBITS; i++) begin : g_step
    logic [DIV_W-1:0] rem_in, den_in;
    logic [QBITS-1:0] quo_in;
    div_mode_t        mode_in;
    logic [DIV_W:0]   shl, diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign quo_in  = '0;
      assign mode_in = mode;
    end else begin : g_rest
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign mode_in = mode_r[i-1];
    end

    assign shl  = {rem_in, 1'b0};
    assign ge   = shl >= {1'b0, den_in};
    assign diff = shl - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DIV_W-1:0] : shl[DIV_W-1:0];
        den_r[i]  <= den_in;
        quo_r[i]  <= {quo_in[QBITS-2:0], ge};
        mode_r[i] <= mode_in;
      end
    end
  end

  always_comb begin
    unique case (mode_r[QBITS-1])
      DIV_ZERO: frac = '0;
      DIV_ONE:  frac = FRAC_ONE;
      DIV_RUN:  frac = {1'b0, quo_r[QBITS-1]};
      default:  frac = '0;
    endcase
  end

endmodule

[hdl/segment_segment_distance_sq.sv]
// Top level: squared closest distance between two 3-D segments, fully pipelined.
//
// Usage:
//   Input channel seg_valid / seg_stall / seg_pair carries one request: the
//   four Q12.12 endpoints of segments A and B. Output channel dist_valid /
//   dist_stall / dist_item returns the squared distance in Q28.24 with a
//   saturation flag. A request is taken at an edge with valid high and
//   stall low, on either side.
//   A chain of 50 register stages lies between the accepting edge and
//   dist_valid. One request is taken every cycle unless the output stalls;
//   the 32-stage divider pair and the split 60x60 multipliers set the
//   depth, each stage holding one wide add or one partial-product row.
//   cfg_write_en / cfg_write_data load near_zero_threshold (reset 1); load
//   it only while the pipeline is empty.
//   Synchronous reset clears all valid bits and sets the threshold back to
//   1; data registers are left as they are.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and seg_stall rises; nothing is dropped or repeated.
module segment_segment_distance_sq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       seg_valid,
  output logic                       seg_stall,
  input  ssd_pkg::seg_pair_t         seg_pair,
  output logic                       dist_valid,
  input  logic                       dist_stall,
  output ssd_pkg::dist_item_t        dist_item,
  input  logic                       cfg_write_en,
  input  logic [ssd_pkg::THR_W-1:0]  cfg_write_data
);
  import ssd_pkg::*;

  // stage indexes along the valid chain
  localparam int S11     = 10;
  localparam int DIV_OUT = S11 + QBITS;
  localparam int VEC_DLY = DIV_OUT + 1;
  localparam int LAT     = DIV_OUT + 2 + MUL_LAT + 3;

  logic [THR_W-1:0] thr;
  logic [LAT-1:0]   vld;
  logic             en;

  // pipeline moves as one unit; hold all of it while the output is stalled
  assign en         = !(vld[LAT-1] && dist_stall);
  assign seg_stall  = !en;
  assign dist_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
      vld <= '0;
    end else begin
      if (cfg_write_en) begin
        thr <= cfg_write_data;
      end
      if (en) begin
        vld <= {vld[LAT-2:0], seg_valid};
      end
    end
  end

  // ---- S1: edge and offset vectors ----
  vec_t vec_next;
  vec_t vec_d [VEC_DLY];

  always_comb begin
    vec_next.u[0] = sub_c(seg_pair.seg_a_end_x, seg_pair.seg_a_start_x);
    vec_next.u[1] = sub_c(seg_pair.seg_a_end_y, seg_pair.seg_a_start_y);
    vec_next.u[2] = sub_c(seg_pair.seg_a_end_z, seg_pair.seg_a_start_z);
    vec_next.v[0] = sub_c(seg_pair.seg_b_end_x, seg_pair.seg_b_start_x);
    vec_next.v[1] = sub_c(seg_pair.seg_b_end_y, seg_pair.seg_b_start_y);
    vec_next.v[2] = sub_c(seg_pair.seg_b_end_z, seg_pair.seg_b_start_z);
    vec_next.w[0] = sub_c(seg_pair.seg_a_start_x, seg_pair.seg_b_start_x);
    vec_next.w[1] = sub_c(seg_pair.seg_a_start_y, seg_pair.seg_b_start_y);
    vec_next.w[2] = sub_c(seg_pair.seg_a_start_z, seg_pair.seg_b_start_z);
  end

  // vectors ride along until the distance stages need them
  always_ff @(posedge clk) begin
    if (en) begin
      vec_d[0] <= vec_next;
      for (int k = 1; k < VEC_DLY; k++) begin
        vec_d[k] <= vec_d[k-1];
      end
    end
  end

  // ---- S2: component products, S3: dot products ----
  pp_t   pp_a [3], pp_b [3], pp_c [3], pp_d [3], pp_e [3];
  dots_t dot_d [MUL_LAT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pp_a[k] <= mul_d(vec_d[0].u[k], vec_d[0].u[k]);
        pp_b[k] <= mul_d(vec_d[0].u[k], vec_d[0].v[k]);
        pp_c[k] <= mul_d(vec_d[0].v[k], vec_d[0].v[k]);
        pp_d[k] <= mul_d(vec_d[0].u[k], vec_d[0].w[k]);
        pp_e[k] <= mul_d(vec_d[0].v[k], vec_d[0].w[k]);
      end
      dot_d[0].a <= dot_t'(pp_a[0]) + dot_t'(pp_a[1]) + dot_t'(pp_a[2]);
      dot_d[0].b <= dot_t'(pp_b[0]) + dot_t'(pp_b[1]) + dot_t'(pp_b[2]);
      dot_d[0].c <= dot_t'(pp_c[0]) + dot_t'(pp_c[1]) + dot_t'(pp_c[2]);
      dot_d[0].d <= dot_t'(pp_d[0]) + dot_t'(pp_d[1]) + dot_t'(pp_d[2]);
      dot_d[0].e <= dot_t'(pp_e[0]) + dot_t'(pp_e[1]) + dot_t'(pp_e[2]);
      for (int k = 1; k <= MUL_LAT; k++) begin
        dot_d[k] <= dot_d[k-1];
      end
    end
  end

  // ---- S4..S6: cross products of the dot products ----
  prod_t p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

  ssd_mul u_mul_ac (.clk, .en, .a(mulin_t'(dot_d[0].a)), .b(mulin_t'(dot_d[0].c)), .p(p_ac));
  ssd_mul u_mul_bb (.clk, .en, .a(mulin_t'(dot_d[0].b)), .b(mulin_t'(dot_d[0].b)), .p(p_bb));
  ssd_mul u_mul_be (.clk, .en, .a(mulin_t'(dot_d[0].b)), .b(mulin_t'(dot_d[0].e)), .p(p_be));
  ssd_mul u_mul_cd (.clk, .en, .a(mulin_t'(dot_d[0].c)), .b(mulin_t'(dot_d[0].d)), .p(p_cd));
  ssd_mul u_mul_ae (.clk, .en, .a(mulin_t'(dot_d[0].a)), .b(mulin_t'(dot_d[0].e)), .p(p_ae));
  ssd_mul u_mul_bd (.clk, .en, .a(mulin_t'(dot_d[0].b)), .b(mulin_t'(dot_d[0].d)), .p(p_bd));

  // ---- S7: determinant and unclamped numerators ----
  wide_t det7, snum7, tnum7;
  dot_t  a7, c7, e7;
  alt_t  alt07, alt17, eb7;

  always_ff @(posedge clk) begin
    if (en) begin
      det7  <= wide_t'(p_ac) - wide_t'(p_bb);
      snum7 <= wide_t'(p_be) - wide_t'(p_cd);
      tnum7 <= wide_t'(p_ae) - wide_t'(p_bd);
      a7    <= dot_d[MUL_LAT].a;
      c7    <= dot_d[MUL_LAT].c;
      e7    <= dot_d[MUL_LAT].e;
      alt07 <= -alt_t'(dot_d[MUL_LAT].d);
      alt17 <= alt_t'(dot_d[MUL_LAT].b) - alt_t'(dot_d[MUL_LAT].d);
      eb7   <= alt_t'(dot_d[MUL_LAT].e) + alt_t'(dot_d[MUL_LAT].b);
    end
  end

  // ---- S8: compare flags ----
  wide_t det8, snum8, tnum8;
  dot_t  a8, c8, e8;
  alt_t  alt08, alt18, eb8;
  logic  near8, sneg8, sgt8, a0neg8, a0gt8, a1neg8, a1gt8;

  always_ff @(posedge clk) begin
    if (en) begin
      det8   <= det7;
      snum8  <= snum7;
      tnum8  <= tnum7;
      a8     <= a7;
      c8     <= c7;
      e8     <= e7;
      alt08  <= alt07;
      alt18  <= alt17;
      eb8    <= eb7;
      near8  <= is_near(det7, thr);
      sneg8  <= snum7[WIDE_W-1];
      sgt8   <= snum7 > det7;
      a0neg8 <= alt07[ALT_W-1];
      a0gt8  <= alt07 > alt_t'(a7);
      a1neg8 <= alt17[ALT_W-1];
      a1gt8  <= alt17 > alt_t'(a7);
    end
  end

  // ---- S9: clamp s to its edges, choose t numerator ----
  wide_t snum9, sden9, tnum9, tden9;
  wide_t snum9_next, sden9_next, tnum9_next, tden9_next;
  dot_t  a9;
  alt_t  alt09, alt19;
  logic  a0neg9, a0gt9, a1neg9, a1gt9;

  always_comb begin
    sden9_next = det8;
    tden9_next = wide_t'(c8);
    priority if (near8) begin
      snum9_next = '0;
      sden9_next = wide_t'(1);
      tnum9_next = wide_t'(e8);
    end else if (sneg8) begin
      snum9_next = '0;
      tnum9_next = wide_t'(e8);
    end else if (sgt8) begin
      snum9_next = det8;
      tnum9_next = wide_t'(eb8);
    end else begin
      snum9_next = snum8;
      tnum9_next = tnum8;
      tden9_next = det8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snum9  <= snum9_next;
      sden9  <= sden9_next;
      tnum9  <= tnum9_next;
      tden9  <= tden9_next;
      a9     <= a8;
      alt09  <= alt08;
      alt19  <= alt18;
      a0neg9 <= a0neg8;
      a0gt9  <= a0gt8;
      a1neg9 <= a1neg8;
      a1gt9  <= a1gt8;
    end
  end

  // ---- S10: t range flags ----
  wide_t snum10, sden10, tnum10, tden10;
  dot_t  a10;
  alt_t  alt010, alt110;
  logic  a0neg10, a0gt10, a1neg10, a1gt10, tneg10, tgt10;

  always_ff @(posedge clk) begin
    if (en) begin
      snum10  <= snum9;
      sden10  <= sden9;
      tnum10  <= tnum9;
      tden10  <= tden9;
      a10     <= a9;
      alt010  <= alt09;
      alt110  <= alt19;
      a0neg10 <= a0neg9;
      a0gt10  <= a0gt9;
      a1neg10 <= a1neg9;
      a1gt10  <= a1gt9;
      tneg10  <= tnum9[WIDE_W-1];
      tgt10   <= tnum9 > tden9;
    end
  end

  // ---- S11: clamp t, then recompute s on that edge ----
  wide_t snum11, sden11, tnum11, tden11;
  wide_t snum11_next, sden11_next, tnum11_next;
  alt_t  alt_sel;
  logic  aneg_sel, agt_sel;

  always_comb begin
    snum11_next = snum10;
    sden11_next = sden10;
    tnum11_next = tnum10;
    alt_sel     = alt010;
    aneg_sel    = a0neg10;
    agt_sel     = a0gt10;
    if (tneg10 || tgt10) begin
      if (tneg10) begin
        tnum11_next = '0;
      end else begin
        tnum11_next = tden10;
        alt_sel     = alt110;
        aneg_sel    = a1neg10;
        agt_sel     = a1gt10;
      end
      priority if (aneg_sel) begin
        snum11_next = '0;
      end else if (agt_sel) begin
        snum11_next = sden10;
      end else begin
        snum11_next = wide_t'(alt_sel);
        sden11_next = wide_t'(a10);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snum11 <= snum11_next;
      sden11 <= sden11_next;
      tnum11 <= tnum11_next;
      tden11 <= tden10;
    end
  end

  // ---- S12..S43: parameter division ----
  frac_t s_frac, t_frac;

  ssd_div u_div_s (
    .clk, .en,
    .mode (div_mode(snum11, sden11, thr)),
    .num  (snum11[DIV_W-1:0]),
    .den  (sden11[DIV_W-1:0]),
    .frac (s_frac)
  );

  ssd_div u_div_t (
    .clk, .en,
    .mode (div_mode(tnum11, tden11, thr)),
    .num  (tnum11[DIV_W-1:0]),
    .den  (tden11[DIV_W-1:0]),
    .frac (t_frac)
  );

  // ---- P1: scaled edge terms, P2: difference components ----
  term_t  su [3], tv [3];
  diff_t  wp [3];
  mulin_t comp [3];
  prod_t  sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        su[k]   <= term_t'($signed({1'b0, s_frac})) * term_t'(vec_d[VEC_DLY-1].u[k]);
        tv[k]   <= term_t'($signed({1'b0, t_frac})) * term_t'(vec_d[VEC_DLY-1].v[k]);
        wp[k]   <= vec_d[VEC_DLY-1].w[k];
        comp[k] <= (mulin_t'(wp[k]) <<< QBITS) + mulin_t'(su[k]) - mulin_t'(tv[k]);
      end
    end
  end

  // ---- P3..P5: squares ----
  for (genvar k = 0; k < 3; k++) begin : g_sq
    ssd_mul u_mul_sq (.clk, .en, .a(comp[k]), .b(comp[k]), .p(sq[k]));
  end

  // ---- P6: sum with rounding, P7: saturate into the output register ----
  sum_t sum;
  logic sat;

  assign sat = |sum[SUM_W-1:OUT_W+2*QBITS];

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_t'(sq[0]) + sum_t'(sq[1]) + sum_t'(sq[2]) + ROUND_HALF;
      dist_item.saturated   <= sat;
      dist_item.distance_sq <= sat ? '1 : sum[OUT_W+2*QBITS-1:2*QBITS];
    end
  end

  // ---- checks ----
  assert property (@(posedge clk) disable iff (rst)
    vld[S11] |-> (tnum11 >= wide_t'(0)) && (tnum11 <= tden11))
    else $error("t numerator outside its clamped range");

  assert property (@(posedge clk) disable iff (rst)
    vld[DIV_OUT] |-> (s_frac <= FRAC_ONE) && (t_frac <= FRAC_ONE))
    else $error("segment parameter above one");

  assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_item.saturated |-> dist_item.distance_sq == '1)
    else $error("saturated result not at full scale");

  assert property (@(posedge clk)
    $past(rst) |-> !dist_valid)
    else $error("result valid right after reset");

endmodule
